FILE: hdl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/vdd_pkg.sv
`default_nettype none

package vdd_pkg;

    // Field and accumulator widths
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 64;
    localparam int COORD_W   = 20;
    localparam int INDEX_BITS = 20;
    // Index bits that take part in the sparse match
    localparam int CMP_BITS  = (INDEX_BITS < COORD_W) ? INDEX_BITS : COORD_W;

    // Front-to-back queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FUNC_DENSE  = 2'd0,
        FUNC_FIRST  = 2'd1,
        FUNC_SECOND = 2'd2
    } t_func;

    // One classified transaction handed from front to back
    typedef struct packed {
        logic signed [VAL_W-1:0] dot_x;
        logic signed [VAL_W-1:0] dot_y;
        logic signed [VAL_W-1:0] sq_first;
        logic signed [VAL_W-1:0] sq_second;
        logic        [VAL_W-1:0] mag;
        logic                    sparse;
        logic                    last;
    } t_op;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } t_q_status;

    // Add two signed values and clamp to the signed range
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/vdd_front.sv
`default_nettype none

module vdd_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_func,
    input  wire logic [vdd_pkg::COORD_W-1:0]   i_coord_index,
    input  wire logic signed [vdd_pkg::VAL_W-1:0] i_value_first,
    input  wire logic signed [vdd_pkg::VAL_W-1:0] i_value_second,
    input  wire logic                          i_last,
    input  wire vdd_pkg::t_q_status            i_q_status,
    output logic                               o_push,
    output vdd_pkg::t_op                       o_op
);
    import vdd_pkg::*;

    logic                    r_pend_valid, n_pend_valid;
    logic                    r_pend_side,  n_pend_side;
    logic [CMP_BITS-1:0]     r_pend_index, n_pend_index;
    logic signed [VAL_W-1:0] r_pend_value, n_pend_value;

    logic                    accept;
    logic [CMP_BITS-1:0]     idx;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          diff_abs;
    logic                    side;
    logic signed [VAL_W-1:0] sval;
    logic                    match;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign idx        = i_coord_index[CMP_BITS-1:0];

    // Magnitude of the coordinate difference; always fits in 32 bits
    assign diff     = {i_value_first[VAL_W-1], i_value_first}
                    - {i_value_second[VAL_W-1], i_value_second};
    assign diff_abs = diff[VAL_W] ? -diff : diff;

    assign side  = (i_func == FUNC_SECOND);
    assign sval  = side ? i_value_second : i_value_first;
    assign match = r_pend_valid && (r_pend_side != side) && (r_pend_index == idx);

    // Classify the transaction and track the pending sparse element
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_side  = r_pend_side;
        n_pend_index = r_pend_index;
        n_pend_value = r_pend_value;

        o_op.dot_x     = '0;
        o_op.dot_y     = '0;
        o_op.sq_first  = '0;
        o_op.sq_second = '0;
        o_op.mag       = '0;
        o_op.sparse    = 1'b0;
        o_op.last      = i_last;

        case (i_func)
            FUNC_DENSE: begin
                o_op.dot_x     = i_value_first;
                o_op.dot_y     = i_value_second;
                o_op.sq_first  = i_value_first;
                o_op.sq_second = i_value_second;
                o_op.mag       = diff_abs[VAL_W-1:0];
                n_pend_valid   = 1'b0;
            end
            FUNC_FIRST, FUNC_SECOND: begin
                o_op.sparse = 1'b1;
                if (side) begin
                    o_op.sq_second = sval;
                end else begin
                    o_op.sq_first = sval;
                end
                if (match) begin
                    o_op.dot_x   = r_pend_value;
                    o_op.dot_y   = sval;
                    n_pend_valid = 1'b0;
                end else begin
                    n_pend_valid = 1'b1;
                    n_pend_side  = side;
                    n_pend_index = idx;
                    n_pend_value = sval;
                end
            end
            default: begin
            end
        endcase

        // Drop any pending element at the end of a pair
        if (i_last) begin
            n_pend_valid = 1'b0;
            n_pend_side  = 1'b0;
            n_pend_index = '0;
            n_pend_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_side  <= 1'b0;
            r_pend_index <= '0;
            r_pend_value <= '0;
        end else if (accept) begin
            r_pend_valid <= n_pend_valid;
            r_pend_side  <= n_pend_side;
            r_pend_index <= n_pend_index;
            r_pend_value <= n_pend_value;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/vdd_queue.sv
`default_nettype none

module vdd_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire vdd_pkg::t_op       i_op,
    output logic                    o_valid,
    input  wire logic               i_pop,
    output vdd_pkg::t_op            o_op,
    output vdd_pkg::t_q_status      o_status
);
    import vdd_pkg::*;

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_status.count = r_count;
    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid        = (r_count != '0);
    assign o_op           = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && o_valid;

    // Store the incoming transaction
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/vdd_back.sv
`default_nettype none

module vdd_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_op_valid,
    input  wire vdd_pkg::t_op                     i_op,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [vdd_pkg::ACC_W-1:0]      o_dot_product,
    output logic signed [vdd_pkg::ACC_W-1:0]      o_sq_dist,
    output logic [vdd_pkg::VAL_W-1:0]             o_max_diff,
    output logic                                  o_sup_valid
);
    import vdd_pkg::*;

    // Multiply stage
    logic                    r_m_valid, r_m_last, r_m_sparse;
    logic signed [ACC_W-1:0] r_m_dot, r_m_n1, r_m_n2;
    logic [VAL_W-1:0]        r_m_mag;

    // Accumulators
    logic signed [ACC_W-1:0] r_acc_dot, r_acc_n1, r_acc_n2;
    logic [VAL_W-1:0]        r_sup_max;
    logic                    r_all_dense;
    logic signed [ACC_W-1:0] n_acc_dot, n_acc_n1, n_acc_n2;
    logic [VAL_W-1:0]        n_sup_max;
    logic                    n_all_dense;

    // Result stages
    logic                    r_r1_valid, r_r1_sv;
    logic signed [ACC_W-1:0] r_r1_dot, r_r1_n1, r_r1_n2;
    logic [VAL_W-1:0]        r_r1_sup;
    logic                    r_r2_valid, r_r2_sv;
    logic signed [ACC_W-1:0] r_r2_dot;
    logic [ACC_W:0]          r_r2_sum;
    logic [VAL_W-1:0]        r_r2_sup;
    logic                    r_o_valid, r_o_sv;
    logic signed [ACC_W-1:0] r_o_dot, r_o_sq;
    logic [VAL_W-1:0]        r_o_sup;

    logic out_free, r2_free, r2_adv, r1_free, r1_adv, m_adv, m_free, take;
    logic signed [ACC_W+2:0] sq_full;
    logic signed [ACC_W-1:0] sq_sat;

    // Stall chain from the output register back to the queue
    assign out_free = !r_o_valid || i_out_ready;
    assign r2_free  = !r_r2_valid || out_free;
    assign r2_adv   = r_r2_valid && out_free;
    assign r1_free  = !r_r1_valid || r2_free;
    assign r1_adv   = r_r1_valid && r2_free;
    assign m_adv    = r_m_valid && (!r_m_last || r1_free);
    assign m_free   = !r_m_valid || m_adv;
    assign o_pop    = m_free;
    assign take     = i_op_valid && m_free;

    // Fold the multiply stage into the running sums
    always_comb begin
        n_acc_dot   = sat_add(r_acc_dot, r_m_dot);
        n_acc_n1    = sat_add(r_acc_n1, r_m_n1);
        n_acc_n2    = sat_add(r_acc_n2, r_m_n2);
        n_sup_max   = (r_m_mag > r_sup_max) ? r_m_mag : r_sup_max;
        n_all_dense = r_all_dense && !r_m_sparse;
    end

    // Squared distance: norms sum minus twice the dot, then clamp
    assign sq_full = $signed({2'b00, r_r2_sum})
                   - $signed({{2{r_r2_dot[ACC_W-1]}}, r_r2_dot, 1'b0});
    always_comb begin
        if (sq_full[ACC_W+2:ACC_W-1] != '0 && sq_full[ACC_W+2:ACC_W-1] != '1) begin
            sq_sat = sq_full[ACC_W+2] ? ACC_MIN : ACC_MAX;
        end else begin
            sq_sat = sq_full[ACC_W-1:0];
        end
    end

    // Multiply payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_m_dot    <= i_op.dot_x * i_op.dot_y;
            r_m_n1     <= i_op.sq_first * i_op.sq_first;
            r_m_n2     <= i_op.sq_second * i_op.sq_second;
            r_m_mag    <= i_op.mag;
            r_m_sparse <= i_op.sparse;
            r_m_last   <= i_op.last;
        end
    end

    // Result payload stages
    always_ff @(posedge i_clk) begin
        if (m_adv && r_m_last) begin
            r_r1_dot <= n_acc_dot;
            r_r1_n1  <= n_acc_n1;
            r_r1_n2  <= n_acc_n2;
            r_r1_sup <= n_all_dense ? n_sup_max : '0;
            r_r1_sv  <= n_all_dense;
        end
        if (r1_adv) begin
            r_r2_dot <= r_r1_dot;
            r_r2_sum <= {1'b0, r_r1_n1} + {1'b0, r_r1_n2};
            r_r2_sup <= r_r1_sup;
            r_r2_sv  <= r_r1_sv;
        end
        if (r2_adv) begin
            r_o_dot <= r_r2_dot;
            r_o_sq  <= sq_sat;
            r_o_sup <= r_r2_sup;
            r_o_sv  <= r_r2_sv;
        end
    end

    // Stage valids and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_r1_valid  <= 1'b0;
            r_r2_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_acc_dot   <= '0;
            r_acc_n1    <= '0;
            r_acc_n2    <= '0;
            r_sup_max   <= '0;
            r_all_dense <= 1'b1;
        end else begin
            if (take) begin
                r_m_valid <= 1'b1;
            end else if (m_adv) begin
                r_m_valid <= 1'b0;
            end

            if (m_adv) begin
                if (r_m_last) begin
                    r_acc_dot   <= '0;
                    r_acc_n1    <= '0;
                    r_acc_n2    <= '0;
                    r_sup_max   <= '0;
                    r_all_dense <= 1'b1;
                end else begin
                    r_acc_dot   <= n_acc_dot;
                    r_acc_n1    <= n_acc_n1;
                    r_acc_n2    <= n_acc_n2;
                    r_sup_max   <= n_sup_max;
                    r_all_dense <= n_all_dense;
                end
            end

            if (m_adv && r_m_last) begin
                r_r1_valid <= 1'b1;
            end else if (r1_adv) begin
                r_r1_valid <= 1'b0;
            end

            if (r1_adv) begin
                r_r2_valid <= 1'b1;
            end else if (r2_adv) begin
                r_r2_valid <= 1'b0;
            end

            if (r2_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_dot_product = r_o_dot;
    assign o_sq_dist     = r_o_sq;
    assign o_max_diff    = r_o_sup;
    assign o_sup_valid   = r_o_sv;

endmodule

`default_nettype wire

FILE: hdl/vector_dot_and_distance.sv
`default_nettype none
`include "assert_macros.svh"

// Streams one vector pair and returns its dot product, squared Euclidean
// distance and sup distance on the transaction marked last. The block takes
// one transaction per clock cycle unless the queue is full; the rate is
// set by the saturating 64-bit accumulate loop, fed by a stage of three
// 32x32 multipliers. A result passes the multiply and result stages to
// the output register. A four-entry queue between the classifying front
// and the arithmetic back lets either side stall alone. Sparse elements
// must arrive merged in index order; sup distance is reported only when
// every transaction of the pair was dense, and reads zero otherwise.
module vector_dot_and_distance (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [1:0]                       i_func,
    input  wire logic [vdd_pkg::COORD_W-1:0]      i_coord_index,
    input  wire logic signed [vdd_pkg::VAL_W-1:0] i_value_first,
    input  wire logic signed [vdd_pkg::VAL_W-1:0] i_value_second,
    input  wire logic                             i_last,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [vdd_pkg::ACC_W-1:0]      o_dot_product,
    output logic signed [vdd_pkg::ACC_W-1:0]      o_sq_dist,
    output logic [vdd_pkg::VAL_W-1:0]             o_max_diff,
    output logic                                  o_sup_valid
);
    import vdd_pkg::*;

    logic      push, q_valid, pop;
    t_op       front_op, q_op;
    t_q_status q_status;

    // Classify transactions and resolve sparse pairs
    vdd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_coord_index  (i_coord_index),
        .i_value_first  (i_value_first),
        .i_value_second (i_value_second),
        .i_last         (i_last),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_op           (front_op)
    );

    // Decouple front and back
    vdd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (front_op),
        .o_valid  (q_valid),
        .i_pop    (pop),
        .o_op     (q_op),
        .o_status (q_status)
    );

    // Multiply, accumulate and finish the results
    vdd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (q_valid),
        .i_op          (q_op),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_dot_product (o_dot_product),
        .o_sq_dist     (o_sq_dist),
        .o_max_diff    (o_max_diff),
        .o_sup_valid   (o_sup_valid)
    );

    `ASSERT_ALWAYS(a_q_bound, q_status.count <= QCNT_W'(QDEPTH), "queue over its depth")
    `ASSERT_IMPLY(a_ready_full, !o_in_ready, q_status.full, "stall without full queue")
    `ASSERT_IMPLY(a_sup_zero, o_out_valid && !o_sup_valid, o_max_diff == '0, "sup not zero")
    `ASSERT_IMPLY(a_push_room, push, !q_status.full, "push into full queue")

endmodule

`default_nettype wire
